FILE: hdl/usd_pkg.sv
`timescale 1ns / 1ps

package usd_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 24;
  localparam int LIMIT_W        = 24;
  localparam int USER_W         = 3;

  // register indexes on the config channel
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CODEPOINTS = 1'b1;

  // stop reasons
  localparam logic [1:0] REASON_END_OF_INPUT = 2'd0;
  localparam logic [1:0] REASON_LIMIT        = 2'd1;
  localparam logic [1:0] REASON_MALFORMED    = 2'd2;

  typedef struct packed {
    logic               limit_enable;
    logic [LIMIT_W-1:0] max_codepoints;
  } cfg_regs_t;

  // result word width: codepoint, length, both counters, padded to bytes
  function automatic int data_width(input int count_bits);
    return ((21 + 3 + count_bits + count_bits + 2 + 7) / 8) * 8;
  endfunction

endpackage

FILE: hdl/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// channel   dir  handshake                word
// s_*       in   s_tvalid / s_tready      tdata = data_byte, tlast = end_of_string
// m_*       out  m_tvalid / m_tready      tdata = code point and counters, tuser = flags,
//                                         tlast = stopped
// cfg_*     in   cfg_valid / cfg_ready    cfg_index selects the register, cfg_data its value
//
// one byte per cycle while s_tready is high; a byte's result word, if any, is on m_tdata
// the cycle after it is taken unless an earlier word still waits; the decode state
// updates in the same cycle the byte is taken; a two-entry buffer keeps s_tready registered
// s_tready drops only when both output entries are full; cfg_ready is always high
// rst is synchronous: decode state, counters and registers clear to zero

module utf8_stream_decoder
  import usd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // data_byte
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // codepoint[20:0], sequence_length, codepoints_so_far, bytes_so_far, zero pad
  output logic [data_width(COUNT_BITS)-1:0] m_tdata,
  output logic [USER_W-1:0]                m_tuser,   // has_codepoint, stop_reason[1:0]
  output logic                             m_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_IDX_W-1:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]            cfg_data
);

  localparam int DATA_W = data_width(COUNT_BITS);
  localparam int WORD_W = DATA_W + USER_W + 1;

  cfg_regs_t         cfg;
  logic              take;
  logic              res_valid;
  logic [DATA_W-1:0] res_data;
  logic [USER_W-1:0] res_user;
  logic              res_last;
  logic [WORD_W-1:0] out_word;

  assign cfg_ready = 1'b1;
  assign take      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.limit_enable   <= 1'b0;
      cfg.max_codepoints <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LIMIT_ENABLE:   cfg.limit_enable   <= cfg_data[0];
        REG_MAX_CODEPOINTS: cfg.max_codepoints <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  usd_step #(
    .COUNT_BITS(COUNT_BITS),
    .DATA_W    (DATA_W)
  ) u_step (
    .clk          (clk),
    .rst          (rst),
    .in_take      (take),
    .data_byte    (s_tdata),
    .end_of_string(s_tlast),
    .cfg          (cfg),
    .res_valid    (res_valid),
    .res_data     (res_data),
    .res_user     (res_user),
    .res_last     (res_last)
  );

  usd_skid #(
    .WIDTH(WORD_W)
  ) u_skid (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .push_word({res_last, res_user, res_data}),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_word (out_word),
    .out_ready(m_tready)
  );

  assign m_tdata = out_word[DATA_W-1:0];
  assign m_tuser = out_word[DATA_W +: USER_W];
  assign m_tlast = out_word[WORD_W-1];

endmodule

FILE: hdl/usd_step.sv
`timescale 1ns / 1ps

module usd_step
  import usd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int DATA_W     = data_width(COUNT_BITS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_take,
  input  logic [7:0]        data_byte,
  input  logic              end_of_string,
  input  cfg_regs_t         cfg,
  output logic              res_valid,
  output logic [DATA_W-1:0] res_data,
  output logic [USER_W-1:0] res_user,
  output logic              res_last
);

  localparam int BYTE_BITS = COUNT_BITS + 2;
  localparam int RAW_W     = 21 + 3 + COUNT_BITS + BYTE_BITS;
  localparam int CMP_W     = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  logic [20:0]          partial_value, partial_value_next;
  logic [2:0]           expected_length, expected_length_next;
  logic [2:0]           bytes_seen, bytes_seen_next;
  logic                 bad_pending, bad_pending_next;
  logic                 discarding, discarding_next;
  logic [COUNT_BITS-1:0] codepoint_total, codepoint_total_next;
  logic [BYTE_BITS-1:0]  byte_total, byte_total_next;

  logic                 has, stop;
  logic [1:0]           reason;
  logic [20:0]          cp;
  logic [2:0]           len;
  logic [2:0]           lead_len;
  logic [20:0]          lead_payload;
  logic [20:0]          shifted;
  logic [2:0]           seen_inc;
  logic [20:0]          min_value;
  logic                 seq_ok;
  logic                 at_limit;
  logic [BYTE_BITS:0]   byte_sum;
  logic [RAW_W-1:0]     raw;
  // counters as reported: after this byte's update, before the end-of-string clear
  logic [COUNT_BITS-1:0] cp_report;
  logic [BYTE_BITS-1:0]  bt_report;

  always_comb begin
    lead_len     = 3'd0;
    lead_payload = '0;
    if (data_byte[7] == 1'b0) begin
      lead_len = 3'd1; lead_payload = {14'd0, data_byte[6:0]};
    end else if (data_byte[7:5] == 3'b110) begin
      lead_len = 3'd2; lead_payload = {16'd0, data_byte[4:0]};
    end else if (data_byte[7:4] == 4'b1110) begin
      lead_len = 3'd3; lead_payload = {17'd0, data_byte[3:0]};
    end else if (data_byte[7:3] == 5'b11110) begin
      lead_len = 3'd4; lead_payload = {18'd0, data_byte[2:0]};
    end
  end

  always_comb begin
    unique case (expected_length)
      3'd2:    min_value = 21'h00080;
      3'd3:    min_value = 21'h00800;
      3'd4:    min_value = 21'h10000;
      default: min_value = 21'h00000;
    endcase
  end

  assign shifted  = {partial_value[14:0], data_byte[5:0]};
  assign seen_inc = bytes_seen + 3'd1;
  assign seq_ok   = !bad_pending && (data_byte[7:6] == 2'b10)
                    && (expected_length <= 3'd4) && (shifted >= min_value)
                    && !(shifted >= 21'h00D800 && shifted <= 21'h00DFFF)
                    && (shifted <= 21'h10FFFF);
  assign at_limit = cfg.limit_enable
                    && (CMP_W'(codepoint_total) >= CMP_W'(cfg.max_codepoints));

  always_comb begin
    has                  = 1'b0;
    stop                 = 1'b0;
    reason               = REASON_END_OF_INPUT;
    cp                   = '0;
    len                  = '0;
    partial_value_next   = partial_value;
    expected_length_next = expected_length;
    bytes_seen_next      = bytes_seen;
    bad_pending_next     = bad_pending;
    discarding_next      = discarding;
    codepoint_total_next = codepoint_total;
    byte_total_next      = byte_total;
    byte_sum             = '0;

    if (!discarding) begin
      if (expected_length == 3'd0) begin
        if (at_limit) begin
          stop   = 1'b1;
          reason = REASON_LIMIT;
        end else if (lead_len == 3'd0) begin
          stop   = 1'b1;
          reason = REASON_MALFORMED;
        end else if (lead_len == 3'd1) begin
          has = 1'b1;
          cp  = lead_payload;
          len = 3'd1;
        end else begin
          expected_length_next = lead_len;
          bytes_seen_next      = 3'd1;
          partial_value_next   = lead_payload;
          bad_pending_next     = 1'b0;
        end
      end else begin
        // continuation byte, checked once the announced length is reached
        partial_value_next = shifted;
        bytes_seen_next    = seen_inc;
        if (data_byte[7:6] != 2'b10) bad_pending_next = 1'b1;
        if (seen_inc >= expected_length) begin
          expected_length_next = '0;
          bytes_seen_next      = '0;
          partial_value_next   = '0;
          bad_pending_next     = 1'b0;
          if (seq_ok) begin
            has = 1'b1;
            cp  = shifted;
            len = expected_length;
          end else begin
            stop   = 1'b1;
            reason = REASON_MALFORMED;
          end
        end
      end

      if (has) begin
        if (codepoint_total != '1) codepoint_total_next = codepoint_total + 1'b1;
        byte_sum = {1'b0, byte_total} + (BYTE_BITS + 1)'(len);
        byte_total_next = byte_sum[BYTE_BITS] ? '1 : byte_sum[BYTE_BITS-1:0];
      end

      if (!stop && end_of_string) begin
        stop   = 1'b1;
        reason = REASON_END_OF_INPUT;
      end

      if (stop) begin
        expected_length_next = '0;
        bytes_seen_next      = '0;
        partial_value_next   = '0;
        bad_pending_next     = 1'b0;
        discarding_next      = 1'b1;
      end
    end

    // end flag always closes the string
    if (end_of_string) begin
      partial_value_next   = '0;
      expected_length_next = '0;
      bytes_seen_next      = '0;
      bad_pending_next     = 1'b0;
      discarding_next      = 1'b0;
      codepoint_total_next = '0;
      byte_total_next      = '0;
    end
  end

  always_comb begin
    cp_report = codepoint_total;
    bt_report = byte_total;
    if (has) begin
      if (codepoint_total != '1) cp_report = codepoint_total + 1'b1;
      bt_report = byte_sum[BYTE_BITS] ? '1 : byte_sum[BYTE_BITS-1:0];
    end
  end

  assign raw       = {bt_report, cp_report, len, cp};
  assign res_valid = in_take && !discarding && (has || stop);
  assign res_data  = DATA_W'(raw);
  assign res_user  = {reason, has};
  assign res_last  = stop;

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      expected_length <= '0;
      bytes_seen      <= '0;
      bad_pending     <= 1'b0;
      discarding      <= 1'b0;
      codepoint_total <= '0;
      byte_total      <= '0;
    end else if (in_take) begin
      partial_value   <= partial_value_next;
      expected_length <= expected_length_next;
      bytes_seen      <= bytes_seen_next;
      bad_pending     <= bad_pending_next;
      discarding      <= discarding_next;
      codepoint_total <= codepoint_total_next;
      byte_total      <= byte_total_next;
    end
  end

endmodule

FILE: hdl/usd_skid.sv
`timescale 1ns / 1ps

module usd_skid #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_word,
  output logic             in_ready,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_word,
  input  logic             out_ready
);

  logic             main_valid;
  logic             spare_valid;
  logic [WIDTH-1:0] main_word;
  logic [WIDTH-1:0] spare_word;
  logic             pop;

  assign in_ready  = !spare_valid;
  assign out_valid = main_valid;
  assign out_word  = main_word;
  assign pop       = main_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (pop) begin
      if (spare_valid) begin
        main_valid  <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (!main_valid) main_valid <= 1'b1;
      else spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (spare_valid) main_word <= spare_word;
      else if (push) main_word <= push_word;
    end else if (push) begin
      if (!main_valid) main_word <= push_word;
      else spare_word <= push_word;
    end
  end

endmodule
